// ----- src/mtc_pkg.sv -----
// ----------------------------------------------------------------------------
// mtc_pkg
// Shared types, register indexes and constants for the magnetometer trim
// compensation pipeline.
// ----------------------------------------------------------------------------
package mtc_pkg;

	localparam int CFG_IDX_W     = 4;
	localparam int CFG_DATA_W    = 16;
	localparam int DIV_NUM_W     = 32;
	localparam int DIV_DEN_W     = 17;
	localparam int DIV_STEP_BITS = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_XY_OFFSETS     = 4'd0,
		REG_XY_GAINS       = 4'd1,
		REG_XY_CURVATURE   = 4'd2,
		REG_HALL_REFERENCE = 4'd3,
		REG_Z_GAIN         = 4'd4,
		REG_Z_BASE_DIVISOR = 4'd5,
		REG_Z_HALL_COEFF   = 4'd6,
		REG_Z_OFFSET       = 4'd7
	} cfg_reg_t;

	localparam logic signed [12:0] XY_RAW_OVF = 13'sh1000;
	localparam logic signed [14:0] Z_RAW_OVF  = 15'sh4000;
	localparam logic signed [15:0] OVF_OUT    = 16'sh8000;
	localparam logic [15:0]        RATIO_BIAS = 16'h4000;
	localparam logic signed [31:0] T7_BIAS    = 32'sh0010_0000;
	localparam logic signed [31:0] GAIN_BIAS  = 32'sd160;
	localparam logic [31:0]        HALL_ROUND = 32'd32768;
	localparam logic signed [31:0] Z_SAT      = 32'sd32767;

	typedef struct packed {
		logic signed [12:0] raw_x;
		logic signed [12:0] raw_y;
		logic               xbad;
		logic               ybad;
		logic               zbad;
		logic signed [15:0] comp_z;
	} side_t;

	// signed division by 2**k, truncating toward zero
	function automatic logic signed [31:0] sdiv_pow2(input logic signed [31:0] v,
		input int unsigned k);
		logic signed [31:0] bias;
		bias = v[31] ? 32'((64'd1 << k) - 64'd1) : 32'sd0;
		return (v + bias) >>> k;
	endfunction

endpackage

// ----- src/mtc_div.sv -----
// ----------------------------------------------------------------------------
// mtc_div
// Pipelined unsigned restoring divider, STEP_BITS quotient bits per stage,
// with a side payload that travels alongside the operands.
// ----------------------------------------------------------------------------
module mtc_div #(
	parameter int NUM_W     = 32,
	parameter int DEN_W     = 17,
	parameter int STEP_BITS = 2,
	parameter int SIDE_W    = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [NUM_W-1:0]  num,
	input  logic [DEN_W-1:0]  den,
	input  logic [SIDE_W-1:0] side_in,
	output logic              out_valid,
	output logic [NUM_W-1:0]  quo,
	output logic [SIDE_W-1:0] side_out
);

	localparam int NSTG = NUM_W / STEP_BITS;

	logic              vld_s  [NSTG];
	logic [DEN_W-1:0]  rem_s  [NSTG];
	logic [NUM_W-1:0]  numr_s [NSTG];
	logic [NUM_W-1:0]  quo_s  [NSTG];
	logic [DEN_W-1:0]  den_s  [NSTG];
	logic [SIDE_W-1:0] side_s [NSTG];

	logic              vld_in  [NSTG];
	logic [DEN_W-1:0]  rem_in  [NSTG];
	logic [NUM_W-1:0]  numr_in [NSTG];
	logic [NUM_W-1:0]  quo_in  [NSTG];
	logic [DEN_W-1:0]  den_in  [NSTG];
	logic [SIDE_W-1:0] side_pin [NSTG];

	logic [DEN_W-1:0]  rem_nx  [NSTG];
	logic [NUM_W-1:0]  numr_nx [NSTG];
	logic [NUM_W-1:0]  quo_nx  [NSTG];

	for (genvar g = 0; g < NSTG; g++) begin : g_stage
		if (g == 0) begin : g_first
			assign vld_in[g]   = in_valid;
			assign rem_in[g]   = '0;
			assign numr_in[g]  = num;
			assign quo_in[g]   = '0;
			assign den_in[g]   = den;
			assign side_pin[g] = side_in;
		end else begin : g_next
			assign vld_in[g]   = vld_s[g-1];
			assign rem_in[g]   = rem_s[g-1];
			assign numr_in[g]  = numr_s[g-1];
			assign quo_in[g]   = quo_s[g-1];
			assign den_in[g]   = den_s[g-1];
			assign side_pin[g] = side_s[g-1];
		end

		always_comb begin
			logic [DEN_W:0]   t;
			logic [DEN_W-1:0] r;
			logic [NUM_W-1:0] n;
			logic [NUM_W-1:0] q;
			r = rem_in[g];
			n = numr_in[g];
			q = quo_in[g];
			for (int k = 0; k < STEP_BITS; k++) begin
				t = {r, n[NUM_W-1]};
				n = {n[NUM_W-2:0], 1'b0};
				if (t >= {1'b0, den_in[g]}) begin
					r = DEN_W'(t - {1'b0, den_in[g]});
					q = {q[NUM_W-2:0], 1'b1};
				end else begin
					r = t[DEN_W-1:0];
					q = {q[NUM_W-2:0], 1'b0};
				end
			end
			rem_nx[g]  = r;
			numr_nx[g] = n;
			quo_nx[g]  = q;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g] <= 1'b0;
			end else if (en) begin
				vld_s[g] <= vld_in[g];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[g]  <= rem_nx[g];
				numr_s[g] <= numr_nx[g];
				quo_s[g]  <= quo_nx[g];
				den_s[g]  <= den_in[g];
				side_s[g] <= side_pin[g];
			end
		end
	end

	assign out_valid = vld_s[NSTG-1];
	assign quo       = quo_s[NSTG-1];
	assign side_out  = side_s[NSTG-1];

endmodule

// ----- src/magnetometer_trim_compensation.sv -----
// ----------------------------------------------------------------------------
// magnetometer_trim_compensation
// Applies factory trim words to one raw magnetometer sample and returns
// compensated X, Y, Z with overflow flags, one sample per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
//  channel  | handshake               | payload
//  ---------+-------------------------+-----------------------------------------
//  input    | in_valid / in_ready     | raw_x, raw_y, raw_z, hall_resistance
//  output   | out_valid / out_ready   | comp_x, comp_y, comp_z, ovf_x/y/z
//  config   | cfg_we (no wait)        | cfg_index, cfg_wdata
//
//  The depth of the two pipelined dividers follows from DIV_STEP_BITS. One
//  transfer per cycle is accepted while the output is not stalled.
//  All stages advance together; a stalled output holds every stage.
//  Reset clears valid bits and trim registers.
// ----------------------------------------------------------------------------
module magnetometer_trim_compensation #(
	parameter int DIV_STEP_BITS = mtc_pkg::DIV_STEP_BITS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic signed [12:0]                 raw_x,
	input  logic signed [12:0]                 raw_y,
	input  logic signed [14:0]                 raw_z,
	input  logic [13:0]                        hall_resistance,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [15:0]                 comp_x,
	output logic signed [15:0]                 comp_y,
	output logic signed [15:0]                 comp_z,
	output logic                               ovf_x,
	output logic                               ovf_y,
	output logic                               ovf_z,
	input  logic                               cfg_we,
	input  logic [mtc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [mtc_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

	import mtc_pkg::*;

	logic [15:0] xy_offsets_q, xy_gains_q, xy_curvature_q, z_gain_q;
	logic [14:0] hall_reference_q;
	logic signed [15:0] z_base_divisor_q, z_hall_coeff_q, z_offset_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xy_offsets_q     <= '0;
			xy_gains_q       <= '0;
			xy_curvature_q   <= '0;
			hall_reference_q <= '0;
			z_gain_q         <= '0;
			z_base_divisor_q <= '0;
			z_hall_coeff_q   <= '0;
			z_offset_q       <= '0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_XY_OFFSETS:     xy_offsets_q     <= cfg_wdata;
				REG_XY_GAINS:       xy_gains_q       <= cfg_wdata;
				REG_XY_CURVATURE:   xy_curvature_q   <= cfg_wdata;
				REG_HALL_REFERENCE: hall_reference_q <= cfg_wdata[14:0];
				REG_Z_GAIN:         z_gain_q         <= cfg_wdata;
				REG_Z_BASE_DIVISOR: z_base_divisor_q <= signed'(cfg_wdata);
				REG_Z_HALL_COEFF:   z_hall_coeff_q   <= signed'(cfg_wdata);
				REG_Z_OFFSET:       z_offset_q       <= signed'(cfg_wdata);
				default: ;
			endcase
		end
	end

	logic signed [7:0] x_offs, y_offs, x_gain, y_gain, quad;
	logic [7:0] lin;

	assign x_offs = signed'(xy_offsets_q[7:0]);
	assign y_offs = signed'(xy_offsets_q[15:8]);
	assign x_gain = signed'(xy_gains_q[7:0]);
	assign y_gain = signed'(xy_gains_q[15:8]);
	assign lin    = xy_curvature_q[7:0];
	assign quad   = signed'(xy_curvature_q[15:8]);

	logic en;
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	// stage 1: Hall products, raw Z offset, XY divisor select
	logic               v_s1;
	logic signed [31:0] prod_a_s1;
	logic [30:0]        h_s1;
	logic signed [16:0] zdiff_s1;
	logic [14:0]        den_s1;
	logic signed [12:0] raw_x_s1, raw_y_s1;
	logic               xbad_s1, ybad_s1, zbad_s1;

	logic signed [15:0] dev;
	logic [14:0]        den_sel;

	assign dev     = 16'(signed'({3'b000, hall_resistance}) - signed'({2'b00, hall_reference_q}));
	assign den_sel = (hall_resistance != '0) ? {1'b0, hall_resistance} : hall_reference_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_a_s1 <= 32'(dev * z_hall_coeff_q);
			h_s1      <= 31'(z_gain_q * {hall_resistance, 1'b0});
			zdiff_s1  <= 17'(raw_z) - 17'(z_offset_q);
			den_s1    <= den_sel;
			raw_x_s1  <= raw_x;
			raw_y_s1  <= raw_y;
			xbad_s1   <= (raw_x == XY_RAW_OVF) || (den_sel == '0);
			ybad_s1   <= (raw_y == XY_RAW_OVF) || (den_sel == '0);
			zbad_s1   <= (raw_z == Z_RAW_OVF) || (z_gain_q == '0) ||
				(z_base_divisor_q == '0) || (hall_resistance == '0) ||
				(hall_reference_q == '0);
		end
	end

	// stage 2: Z numerator and divisor
	logic               v_s2;
	logic signed [31:0] nz_s2;
	logic signed [16:0] div_s2;
	logic [14:0]        den_s2;
	logic signed [12:0] raw_x_s2, raw_y_s2;
	logic               xbad_s2, ybad_s2, zbad_s2;

	logic [31:0]        hsum;
	logic signed [16:0] div_c;

	assign hsum  = {1'b0, h_s1} + HALL_ROUND;
	assign div_c = 17'(z_base_divisor_q) + signed'({1'b0, hsum[31:16]});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nz_s2    <= signed'({zdiff_s1, 15'b0}) - sdiv_pow2(prod_a_s1, 2);
			div_s2   <= div_c;
			den_s2   <= den_s1;
			raw_x_s2 <= raw_x_s1;
			raw_y_s2 <= raw_y_s1;
			xbad_s2  <= xbad_s1;
			ybad_s2  <= ybad_s1;
			zbad_s2  <= zbad_s1 || (div_c == '0);
		end
	end

	// stage 3: magnitudes for the dividers
	logic        v_s3;
	logic [31:0] zn_s3;
	logic [16:0] zd_s3;
	logic        zneg_s3;
	logic [31:0] xyn_s3;
	logic [16:0] xyd_s3;
	side_t       side_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			zn_s3          <= nz_s2[31] ? 32'(-nz_s2) : 32'(nz_s2);
			zd_s3          <= div_s2[16] ? 17'(-div_s2) : 17'(div_s2);
			zneg_s3        <= nz_s2[31] ^ div_s2[16];
			xyn_s3         <= {3'b000, hall_reference_q, 14'b0};
			xyd_s3         <= {2'b00, den_s2};
			side_s3.raw_x  <= raw_x_s2;
			side_s3.raw_y  <= raw_y_s2;
			side_s3.xbad   <= xbad_s2;
			side_s3.ybad   <= ybad_s2;
			side_s3.zbad   <= zbad_s2;
			side_s3.comp_z <= '0;
		end
	end

	logic        vxy_d, vz_d, zneg_d;
	logic [31:0] quo_xy, quo_z;
	side_t       side_d;

	mtc_div #(
		.NUM_W     (DIV_NUM_W),
		.DEN_W     (DIV_DEN_W),
		.STEP_BITS (DIV_STEP_BITS),
		.SIDE_W    ($bits(side_t))
	) u_div_xy (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s3),
		.num       (xyn_s3),
		.den       (xyd_s3),
		.side_in   (side_s3),
		.out_valid (vxy_d),
		.quo       (quo_xy),
		.side_out  (side_d)
	);

	mtc_div #(
		.NUM_W     (DIV_NUM_W),
		.DEN_W     (DIV_DEN_W),
		.STEP_BITS (DIV_STEP_BITS),
		.SIDE_W    (1)
	) u_div_z (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s3),
		.num       (zn_s3),
		.den       (zd_s3),
		.side_in   (zneg_s3),
		.out_valid (vz_d),
		.quo       (quo_z),
		.side_out  (zneg_d)
	);

	// post-division stages 5..13
	logic  v_s5, v_s6, v_s7, v_s8, v_s9, v_s10, v_s11, v_s12;
	side_t side_s5, side_s6, side_s7, side_s8, side_s9, side_s10, side_s11, side_s12;

	logic signed [31:0] qz_s5;
	logic signed [15:0] r_s5;
	logic signed [31:0] sq_s6, t6_s6;
	logic signed [15:0] zsat_s6;
	logic signed [31:0] t4_s7, t6_s7;
	logic signed [31:0] t7_s8;
	logic signed [31:0] t9p_x_s9, t9p_y_s9;
	logic signed [31:0] t9_x_s10, t9_y_s10;
	logic signed [31:0] t10_x_s11, t10_y_s11;
	logic signed [15:0] r2_x_s12, r2_y_s12;

	logic signed [15:0] zsat_c, zfin_c;
	logic signed [31:0] fx_c, fy_c;

	always_comb begin
		if (qz_s5 > Z_SAT) begin
			zsat_c = 16'(Z_SAT);
		end else if (qz_s5 < -Z_SAT) begin
			zsat_c = 16'(-Z_SAT);
		end else begin
			zsat_c = qz_s5[15:0];
		end
	end

	assign zfin_c = 16'(sdiv_pow2(32'(zsat_s6), 4));
	assign fx_c   = sdiv_pow2(32'(r2_x_s12) + (32'(x_offs) <<< 3), 4);
	assign fy_c   = sdiv_pow2(32'(r2_y_s12) + (32'(y_offs) <<< 3), 4);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5      <= 1'b0;
			v_s6      <= 1'b0;
			v_s7      <= 1'b0;
			v_s8      <= 1'b0;
			v_s9      <= 1'b0;
			v_s10     <= 1'b0;
			v_s11     <= 1'b0;
			v_s12     <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			v_s5      <= vxy_d && vz_d;
			v_s6      <= v_s5;
			v_s7      <= v_s6;
			v_s8      <= v_s7;
			v_s9      <= v_s8;
			v_s10     <= v_s9;
			v_s11     <= v_s10;
			v_s12     <= v_s11;
			out_valid <= v_s12;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s5   <= side_d;
			qz_s5     <= zneg_d ? signed'(-quo_z) : signed'(quo_z);
			r_s5      <= signed'(quo_xy[15:0] - RATIO_BIAS);

			side_s6   <= side_s5;
			sq_s6     <= 32'(r_s5) * 32'(r_s5);
			t6_s6     <= 32'(r_s5) * signed'({17'b0, lin, 7'b0});
			zsat_s6   <= zsat_c;

			side_s7   <= '{
				raw_x:  side_s6.raw_x,
				raw_y:  side_s6.raw_y,
				xbad:   side_s6.xbad,
				ybad:   side_s6.ybad,
				zbad:   side_s6.zbad,
				comp_z: side_s6.zbad ? OVF_OUT : zfin_c
			};
			t4_s7     <= 32'(quad) * signed'({8'b0, sq_s6[30:7]});
			t6_s7     <= t6_s6;

			side_s8   <= side_s7;
			t7_s8     <= sdiv_pow2(t4_s7 + t6_s7, 9) + T7_BIAS;

			side_s9   <= side_s8;
			t9p_x_s9  <= t7_s8 * (32'(x_gain) + GAIN_BIAS);
			t9p_y_s9  <= t7_s8 * (32'(y_gain) + GAIN_BIAS);

			side_s10  <= side_s9;
			t9_x_s10  <= sdiv_pow2(t9p_x_s9, 12);
			t9_y_s10  <= sdiv_pow2(t9p_y_s9, 12);

			side_s11  <= side_s10;
			t10_x_s11 <= 32'(side_s10.raw_x) * t9_x_s10;
			t10_y_s11 <= 32'(side_s10.raw_y) * t9_y_s10;

			side_s12  <= side_s11;
			r2_x_s12  <= 16'(sdiv_pow2(t10_x_s11, 13));
			r2_y_s12  <= 16'(sdiv_pow2(t10_y_s11, 13));

			comp_x    <= side_s12.xbad ? OVF_OUT : fx_c[15:0];
			comp_y    <= side_s12.ybad ? OVF_OUT : fy_c[15:0];
			comp_z    <= side_s12.comp_z;
			ovf_x     <= side_s12.xbad;
			ovf_y     <= side_s12.ybad;
			ovf_z     <= side_s12.zbad;
		end
	end

endmodule
